>>> hw/rtl/aci_pkg.sv
// aircon compressor interlock: shared types and constants
// word layouts for the input and result channels, register indexes
// no dependencies
package aci_pkg;

  localparam int unsigned TempOffset = 40;

  typedef enum logic [2:0] {
    CFG_COOLANT_CUT_RAW        = 3'd0,
    CFG_THROTTLE_CUT           = 3'd1,
    CFG_THROTTLE_RELEASE_TICKS = 3'd2,
    CFG_MIN_RPM_TENS           = 3'd3,
    CFG_MAX_RPM_HUNDREDS       = 3'd4,
    CFG_RPM_RELEASE_TICKS      = 3'd5,
    CFG_AFTER_START_TICKS      = 3'd6,
    CFG_COMPRESSOR_DELAY_TICKS = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic signed [8:0] coolant_deg;
    logic [7:0]        throttle;
    logic [15:0]       engine_rpm;
    logic [7:0]        engine_rpm_hundreds;
    logic              engine_running;
    logic              request_active;
  } in_word_t;

  typedef struct packed {
    logic requested;
    logic fan_command;
    logic compressor_on;
    logic coolant_lockout;
    logic throttle_lockout;
    logic rpm_lockout;
  } out_word_t;

  typedef struct packed {
    logic [7:0] coolant_cut_raw;
    logic [7:0] throttle_cut;
    logic [7:0] throttle_release_ticks;
    logic [7:0] min_rpm_tens;
    logic [7:0] max_rpm_hundreds;
    logic [7:0] rpm_release_ticks;
    logic [7:0] after_start_ticks;
    logic [7:0] compressor_delay_ticks;
  } cfg_t;

  typedef struct packed {
    logic [7:0] start_settle_count;
    logic       start_settled;
    logic [7:0] compressor_count;
    logic [7:0] throttle_count;
    logic [7:0] rpm_count;
    logic       coolant_locked;
    logic       throttle_locked;
    logic       rpm_locked;
    logic       compressor_state;
  } state_t;

endpackage

>>> hw/rtl/aci_if.sv
// aircon compressor interlock: valid/ready channel interfaces
// depends on aci_pkg for the word types
interface aci_in_if;
  logic              valid;
  logic              ready;
  aci_pkg::in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface aci_out_if;
  logic               valid;
  logic               ready;
  aci_pkg::out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> hw/rtl/aircon_compressor_interlock.sv
// aircon compressor interlock top level: input register, interlock logic, result register
// depends on aci_pkg and the channel interfaces in aci_if
//
// usage:
//   in_i carries one tick word per 10 Hz tick (coolant, throttle, rpm, running, request).
//   out_o returns one result word per tick: request, fan command, compressor state
//   and the three lockout flags as they stand after that tick.
//   cfg_we_i / cfg_idx_i / cfg_wdata_i write the eight 8-bit registers; write them
//   only while no word is in flight.
// path: an accepted word sits in the input register, is processed combinationally from
//   there and its result is loaded into the result register when that register is free
//   or its result is being taken.
// throughput: one word per cycle while out_o takes results; the whole tick update is a
//   single pass of compares and 8-bit counters between the input and result registers.
// stall: when out_o is not taken, the result register holds and the input register
//   still takes one more word; in_i.ready drops only when both are full.
// reset: rst_ni clears both valid flags, all counters and lockouts, and loads the
//   register defaults (coolant and throttle cuts and max rpm at 255, the rest 0).
module aircon_compressor_interlock (
  input  logic              clk_i,
  input  logic              rst_ni,
  aci_in_if.sink            in_i,
  aci_out_if.source         out_o,
  input  logic              cfg_we_i,
  input  aci_pkg::cfg_idx_e cfg_idx_i,
  input  logic [7:0]        cfg_wdata_i
);

  aci_pkg::cfg_t      cfg_q;
  aci_pkg::state_t    st_q, st_d;
  aci_pkg::in_word_t  s1_word_q;
  logic               s1_valid_q;
  aci_pkg::out_word_t res_d, res_q;
  logic               res_valid_q;
  logic               advance;

  assign advance     = s1_valid_q && (!res_valid_q || out_o.ready);
  assign in_i.ready  = !s1_valid_q || advance;
  assign out_o.valid = res_valid_q;
  assign out_o.data  = res_q;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.coolant_cut_raw        <= 8'd255;
      cfg_q.throttle_cut           <= 8'd255;
      cfg_q.throttle_release_ticks <= 8'd0;
      cfg_q.min_rpm_tens           <= 8'd0;
      cfg_q.max_rpm_hundreds       <= 8'd255;
      cfg_q.rpm_release_ticks      <= 8'd0;
      cfg_q.after_start_ticks      <= 8'd0;
      cfg_q.compressor_delay_ticks <= 8'd0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        aci_pkg::CFG_COOLANT_CUT_RAW:        cfg_q.coolant_cut_raw        <= cfg_wdata_i;
        aci_pkg::CFG_THROTTLE_CUT:           cfg_q.throttle_cut           <= cfg_wdata_i;
        aci_pkg::CFG_THROTTLE_RELEASE_TICKS: cfg_q.throttle_release_ticks <= cfg_wdata_i;
        aci_pkg::CFG_MIN_RPM_TENS:           cfg_q.min_rpm_tens           <= cfg_wdata_i;
        aci_pkg::CFG_MAX_RPM_HUNDREDS:       cfg_q.max_rpm_hundreds       <= cfg_wdata_i;
        aci_pkg::CFG_RPM_RELEASE_TICKS:      cfg_q.rpm_release_ticks      <= cfg_wdata_i;
        aci_pkg::CFG_AFTER_START_TICKS:      cfg_q.after_start_ticks      <= cfg_wdata_i;
        aci_pkg::CFG_COMPRESSOR_DELAY_TICKS: cfg_q.compressor_delay_ticks <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // tick update
  always_comb begin
    logic signed [9:0] coolant;
    logic signed [9:0] limit;
    logic [11:0]       rpm_min;
    logic              thr_high;
    logic              rpm_out;
    logic              permit;

    st_d = st_q;

    if (s1_word_q.engine_running) begin
      if (st_q.start_settle_count >= cfg_q.after_start_ticks) begin
        st_d.start_settled = 1'b1;
      end else begin
        st_d.start_settle_count = st_q.start_settle_count + 8'd1;
      end
    end else begin
      st_d.start_settle_count = 8'd0;
      st_d.start_settled      = 1'b0;
    end

    coolant = 10'(s1_word_q.coolant_deg);
    limit   = $signed({2'b00, cfg_q.coolant_cut_raw}) - 10'(aci_pkg::TempOffset);
    if (coolant > limit) begin
      st_d.coolant_locked = 1'b1;
    end else if (coolant < limit - 10'sd1) begin
      st_d.coolant_locked = 1'b0;
    end

    thr_high = s1_word_q.throttle > cfg_q.throttle_cut;
    if (thr_high) begin
      st_d.throttle_locked = 1'b1;
      st_d.throttle_count  = 8'd0;
    end else if (st_q.throttle_locked) begin
      if (st_q.throttle_count >= cfg_q.throttle_release_ticks) begin
        st_d.throttle_locked = 1'b0;
      end else begin
        st_d.throttle_count = st_q.throttle_count + 8'd1;
      end
    end else begin
      st_d.throttle_count = 8'd0;
    end

    rpm_min = {cfg_q.min_rpm_tens, 3'b000} + {3'b000, cfg_q.min_rpm_tens, 1'b0};
    rpm_out = (s1_word_q.engine_rpm < {4'd0, rpm_min})
           || (s1_word_q.engine_rpm_hundreds > cfg_q.max_rpm_hundreds);
    if (rpm_out) begin
      st_d.rpm_locked = 1'b1;
      st_d.rpm_count  = 8'd0;
    end else if (st_q.rpm_count >= cfg_q.rpm_release_ticks) begin
      st_d.rpm_locked = 1'b0;
    end else begin
      st_d.rpm_count = st_q.rpm_count + 8'd1;
    end

    permit = s1_word_q.request_active && st_d.start_settled && !st_d.throttle_locked
          && !st_d.rpm_locked && !st_d.coolant_locked;
    if (permit) begin
      if (st_q.compressor_count >= cfg_q.compressor_delay_ticks) begin
        st_d.compressor_state = 1'b1;
      end else begin
        st_d.compressor_count = st_q.compressor_count + 8'd1;
      end
    end else begin
      st_d.compressor_state = 1'b0;
      st_d.compressor_count = 8'd0;
    end

    res_d.requested        = s1_word_q.request_active;
    res_d.fan_command      = permit;
    res_d.compressor_on    = st_d.compressor_state;
    res_d.coolant_lockout  = st_d.coolant_locked;
    res_d.throttle_lockout = st_d.throttle_locked;
    res_d.rpm_lockout      = st_d.rpm_locked;
  end

  // interlock state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else if (advance) begin
      st_q <= st_d;
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_word_q <= in_i.data;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (advance) begin
      res_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

endmodule

>>> verif/tb_aircon_compressor_interlock.sv
`timescale 1ns / 1ps
// self-checking testbench for aircon_compressor_interlock: directed and random tick words
// over several register settings and idle mixes, checked against a local tick-level model
// depends on aci_pkg, the channel interfaces in aci_if and the top level
module tb_aircon_compressor_interlock;

  localparam int unsigned WatchdogLimit = 2000;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we;
  aci_pkg::cfg_idx_e cfg_idx;
  logic [7:0] cfg_wdata;

  aci_in_if in_if ();
  aci_out_if out_if ();

  aircon_compressor_interlock dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_if),
    .out_o       (out_if),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  aci_pkg::cfg_t regs;
  aci_pkg::state_t interlock;
  aci_pkg::in_word_t tick_q[$];
  aci_pkg::out_word_t predicted_q[$];
  int unsigned sender_idle_pct;
  int unsigned sink_stall_pct;
  int unsigned fail_count;
  int unsigned quiet_cycles;

  function automatic aci_pkg::out_word_t advance_interlock(aci_pkg::in_word_t w);
    aci_pkg::out_word_t r;
    int coolant;
    int lim;
    logic permit;
    coolant = $signed(w.coolant_deg);
    if (w.engine_running) begin
      if (interlock.start_settle_count >= regs.after_start_ticks) interlock.start_settled = 1'b1;
      else interlock.start_settle_count++;
    end else begin
      interlock.start_settle_count = '0;
      interlock.start_settled = 1'b0;
    end
    lim = int'(regs.coolant_cut_raw) - int'(aci_pkg::TempOffset);
    if (coolant > lim) interlock.coolant_locked = 1'b1;
    else if (coolant < lim - 1) interlock.coolant_locked = 1'b0;
    if (w.throttle > regs.throttle_cut) begin
      interlock.throttle_locked = 1'b1;
      interlock.throttle_count = '0;
    end else if (interlock.throttle_locked) begin
      if (interlock.throttle_count >= regs.throttle_release_ticks) interlock.throttle_locked = 1'b0;
      else interlock.throttle_count++;
    end else begin
      interlock.throttle_count = '0;
    end
    if (int'(w.engine_rpm) < int'(regs.min_rpm_tens) * 10 ||
        w.engine_rpm_hundreds > regs.max_rpm_hundreds) begin
      interlock.rpm_locked = 1'b1;
      interlock.rpm_count = '0;
    end else if (interlock.rpm_count >= regs.rpm_release_ticks) begin
      interlock.rpm_locked = 1'b0;
    end else begin
      interlock.rpm_count++;
    end
    permit = w.request_active && interlock.start_settled && !interlock.throttle_locked &&
             !interlock.rpm_locked && !interlock.coolant_locked;
    if (permit) begin
      if (interlock.compressor_count >= regs.compressor_delay_ticks)
        interlock.compressor_state = 1'b1;
      else interlock.compressor_count++;
    end else begin
      interlock.compressor_state = 1'b0;
      interlock.compressor_count = '0;
    end
    r.requested = w.request_active;
    r.fan_command = permit;
    r.compressor_on = interlock.compressor_state;
    r.coolant_lockout = interlock.coolant_locked;
    r.throttle_lockout = interlock.throttle_locked;
    r.rpm_lockout = interlock.rpm_locked;
    return r;
  endfunction

  function automatic aci_pkg::in_word_t tick_of(int coolant, int thr, int rpm, int rph,
                                                bit run, bit req);
    aci_pkg::in_word_t w;
    w.coolant_deg = 9'(coolant);
    w.throttle = 8'(thr);
    w.engine_rpm = 16'(rpm);
    w.engine_rpm_hundreds = 8'(rph);
    w.engine_running = run;
    w.request_active = req;
    return w;
  endfunction

  // mostly inside every permit, with one limit broken or the engine stopped when disturbed
  function automatic aci_pkg::in_word_t permitted_tick(bit disturb);
    aci_pkg::in_word_t w;
    int lim;
    int hi;
    int c;
    int floor_rpm;
    lim = int'(regs.coolant_cut_raw) - int'(aci_pkg::TempOffset);
    floor_rpm = int'(regs.min_rpm_tens) * 10;
    hi = (lim - 2 < -40) ? -40 : lim - 2;
    if ($urandom_range(4) == 0) c = lim - 2 + int'($urandom_range(3));
    else c = -40 + int'($urandom_range(hi + 40));
    w.throttle = ($urandom_range(7) == 0) ? regs.throttle_cut
                                          : 8'($urandom_range(regs.throttle_cut));
    w.engine_rpm = ($urandom_range(3) == 0) ? 16'(floor_rpm + int'($urandom_range(2)))
                 : 16'(floor_rpm + int'($urandom_range(65535 - floor_rpm)));
    w.engine_rpm_hundreds = ($urandom_range(7) == 0) ? regs.max_rpm_hundreds
                          : 8'($urandom_range(regs.max_rpm_hundreds));
    w.engine_running = ($urandom_range(99) < 98);
    w.request_active = ($urandom_range(99) < 97);
    if (disturb) begin
      case ($urandom_range(4))
        0: if (lim < 215) c = lim + 1 + int'($urandom_range(214 - lim));
        1: if (regs.throttle_cut != 8'hff)
             w.throttle = 8'(int'(regs.throttle_cut) + 1 +
                             int'($urandom_range(254 - int'(regs.throttle_cut))));
        2: if (floor_rpm > 0) w.engine_rpm = 16'($urandom_range(floor_rpm - 1));
        3: if (regs.max_rpm_hundreds != 8'hff)
             w.engine_rpm_hundreds = 8'(int'(regs.max_rpm_hundreds) + 1 +
                                        int'($urandom_range(254 - int'(regs.max_rpm_hundreds))));
        default: w.engine_running = 1'b0;
      endcase
    end
    if (c < -40) c = -40;
    if (c > 215) c = 215;
    w.coolant_deg = 9'(c);
    return w;
  endfunction

  function automatic aci_pkg::in_word_t noise_tick();
    return tick_of(int'($urandom_range(255)) - 40, $urandom_range(255), $urandom_range(65535),
                   $urandom_range(255), 1'($urandom_range(1)), 1'($urandom_range(1)));
  endfunction

  function automatic aci_pkg::cfg_t moderate_setting();
    aci_pkg::cfg_t c;
    c.coolant_cut_raw = 8'($urandom_range(80, 160));
    c.throttle_cut = 8'($urandom_range(100, 240));
    c.throttle_release_ticks = 8'($urandom_range(8));
    c.min_rpm_tens = 8'($urandom_range(100));
    c.max_rpm_hundreds = 8'($urandom_range(20, 120));
    c.rpm_release_ticks = 8'($urandom_range(8));
    c.after_start_ticks = 8'($urandom_range(8));
    c.compressor_delay_ticks = 8'($urandom_range(8));
    return c;
  endfunction

  task automatic write_reg(aci_pkg::cfg_idx_e idx, logic [7:0] value);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic load_setting(aci_pkg::cfg_t c);
    write_reg(aci_pkg::CFG_COOLANT_CUT_RAW, c.coolant_cut_raw);
    write_reg(aci_pkg::CFG_THROTTLE_CUT, c.throttle_cut);
    write_reg(aci_pkg::CFG_THROTTLE_RELEASE_TICKS, c.throttle_release_ticks);
    write_reg(aci_pkg::CFG_MIN_RPM_TENS, c.min_rpm_tens);
    write_reg(aci_pkg::CFG_MAX_RPM_HUNDREDS, c.max_rpm_hundreds);
    write_reg(aci_pkg::CFG_RPM_RELEASE_TICKS, c.rpm_release_ticks);
    write_reg(aci_pkg::CFG_AFTER_START_TICKS, c.after_start_ticks);
    write_reg(aci_pkg::CFG_COMPRESSOR_DELAY_TICKS, c.compressor_delay_ticks);
    regs = c;
  endtask

  task automatic drain();
    do @(negedge clk_i);
    while (tick_q.size() != 0 || in_if.valid || predicted_q.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic random_phase(int n);
    int sent;
    int len;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(9) == 0) begin
        len = $urandom_range(1, 3);
        repeat (len) tick_q.push_back(noise_tick());
      end else begin
        len = $urandom_range(4, 40);
        repeat (len) tick_q.push_back(permitted_tick($urandom_range(99) < 6));
      end
      sent += len;
    end
    drain();
  endtask

  // driver: hold the word until taken
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      in_if.data <= '0;
    end else if (!in_if.valid || in_if.ready) begin
      if (tick_q.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        in_if.valid <= 1'b1;
        in_if.data <= tick_q.pop_front();
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) out_if.ready <= 1'b0;
    else out_if.ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  task automatic compare_flag(string field, logic exp, logic act);
    if (act !== exp) begin
      $display("%0t %s: expected %0b, got %0b", $time, field, exp, act);
      fail_count++;
    end
  endtask

  // monitor: predict on each accepted tick, check each accepted result
  always @(posedge clk_i) begin
    aci_pkg::out_word_t want;
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) predicted_q.push_back(advance_interlock(in_if.data));
      if (out_if.valid && out_if.ready) begin
        if (predicted_q.size() == 0) begin
          $display("%0t unexpected result: expected none, got %b", $time, out_if.data);
          fail_count++;
        end else begin
          want = predicted_q.pop_front();
          compare_flag("requested", want.requested, out_if.data.requested);
          compare_flag("fan_command", want.fan_command, out_if.data.fan_command);
          compare_flag("compressor_on", want.compressor_on, out_if.data.compressor_on);
          compare_flag("coolant_lockout", want.coolant_lockout, out_if.data.coolant_lockout);
          compare_flag("throttle_lockout", want.throttle_lockout,
                       out_if.data.throttle_lockout);
          compare_flag("rpm_lockout", want.rpm_lockout, out_if.data.rpm_lockout);
        end
      end
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) quiet_cycles <= 0;
      else if (quiet_cycles + 1 >= WatchdogLimit) begin
        $display("%0t watchdog: no word moved in %0d cycles", $time, WatchdogLimit);
        $display("tb_aircon_compressor_interlock NOT OK");
        $finish;
      end else quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int idle_send[4];
    int idle_sink[4];
    aci_pkg::cfg_t setting;
    idle_send = '{0, 69, 0, 28};
    idle_sink = '{0, 0, 69, 28};
    rst_ni = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = aci_pkg::CFG_COOLANT_CUT_RAW;
    cfg_wdata = '0;
    in_if.valid = 1'b0;
    in_if.data = '0;
    out_if.ready = 1'b0;
    sender_idle_pct = 0;
    sink_stall_pct = 0;
    fail_count = 0;
    quiet_cycles = 0;
    interlock = '0;
    regs = '0;
    regs.coolant_cut_raw = 8'hff;
    regs.throttle_cut = 8'hff;
    regs.max_rpm_hundreds = 8'hff;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // field extremes under reset defaults
    tick_q.push_back(tick_of(-40, 0, 0, 0, 0, 0));
    tick_q.push_back(tick_of(215, 255, 65535, 255, 1, 1));
    tick_q.push_back(tick_of(0, 128, 32768, 128, 1, 1));
    tick_q.push_back(tick_of(-1, 1, 1, 1, 1, 0));
    drain();

    // coolant limit 60, throttle cut 200, rpm window 800 rpm to 60 hundreds
    setting = '{8'd100, 8'd200, 8'd2, 8'd80, 8'd60, 8'd1, 8'd2, 8'd2};
    load_setting(setting);
    repeat (5) tick_q.push_back(tick_of(20, 50, 1500, 15, 1, 1));
    // coolant hysteresis: lock, hold at limit and limit - 1, release below
    tick_q.push_back(tick_of(61, 50, 1500, 15, 1, 1));
    tick_q.push_back(tick_of(60, 50, 1500, 15, 1, 1));
    tick_q.push_back(tick_of(59, 50, 1500, 15, 1, 1));
    tick_q.push_back(tick_of(58, 50, 1500, 15, 1, 1));
    // throttle lockout and delayed release
    tick_q.push_back(tick_of(20, 201, 1500, 15, 1, 1));
    repeat (3) tick_q.push_back(tick_of(20, 200, 1500, 15, 1, 1));
    // rpm below floor and above ceiling
    tick_q.push_back(tick_of(20, 50, 799, 15, 1, 1));
    tick_q.push_back(tick_of(20, 50, 800, 61, 1, 1));
    repeat (2) tick_q.push_back(tick_of(20, 50, 800, 60, 1, 1));
    // request dropped, engine stopped, then restart
    tick_q.push_back(tick_of(20, 50, 1500, 15, 1, 0));
    tick_q.push_back(tick_of(20, 50, 1500, 15, 0, 1));
    tick_q.push_back(tick_of(20, 50, 1500, 15, 1, 1));
    drain();

    for (int phase = 0; phase < 8; phase++) begin
      if (phase == 0) setting = '1;
      else if (phase == 1) setting = '0;
      else setting = moderate_setting();
      load_setting(setting);
      sender_idle_pct = idle_send[phase % 4];
      sink_stall_pct = idle_sink[phase % 4];
      random_phase(150);
    end

    repeat (10) @(posedge clk_i);
    if (fail_count == 0) $display("tb_aircon_compressor_interlock OK");
    else $display("tb_aircon_compressor_interlock NOT OK");
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/aci_pkg.sv
hw/rtl/aci_if.sv
hw/rtl/aircon_compressor_interlock.sv
verif/tb_aircon_compressor_interlock.sv
